@@ hdl/assert_macros.svh @@
// Assertion macros used by the top level of the mode projection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SWL_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define SWL_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define SWL_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define SWL_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

@@ hdl/swl2mp_pkg.sv @@
// Shared types, constants and the microcode program of the mode projection block.
package swl2mp_pkg;

  localparam int VAL_W = 36;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [4:0] src_t;

  localparam val_t Q30_ONE = 36'sd1073741824;
  localparam val_t COEF_A  = 36'sd169324706;
  localparam val_t COEF_B  = 36'sd338649412;
  localparam val_t COEF_C  = 36'sd414758743;

  // Operand and destination codes.
  localparam src_t SRC_X    = 5'd0;
  localparam src_t SRC_Z    = 5'd1;
  localparam src_t SRC_P    = 5'd2;
  localparam src_t SRC_T    = 5'd3;
  localparam src_t SRC_K    = 5'd4;
  localparam src_t SRC_ST   = 5'd5;
  localparam src_t SRC_CT   = 5'd6;
  localparam src_t SRC_SP   = 5'd7;
  localparam src_t SRC_CP   = 5'd8;
  localparam src_t SRC_S2   = 5'd9;
  localparam src_t SRC_C2   = 5'd10;
  localparam src_t SRC_YR   = 5'd11;
  localparam src_t SRC_YI   = 5'd12;
  localparam src_t SRC_WR   = 5'd13;
  localparam src_t SRC_WI   = 5'd14;
  localparam src_t SRC_NWI  = 5'd15;
  localparam src_t SRC_OMC  = 5'd16;
  localparam src_t SRC_OPC  = 5'd17;
  localparam src_t SRC_HR   = 5'd18;
  localparam src_t SRC_HI   = 5'd19;
  localparam src_t SRC_W    = 5'd20;
  localparam src_t SRC_SRL  = 5'd21;
  localparam src_t SRC_SRH  = 5'd22;
  localparam src_t SRC_SIL  = 5'd23;
  localparam src_t SRC_SIH  = 5'd24;
  localparam src_t SRC_C5   = 5'd25;
  localparam src_t SRC_CA   = 5'd26;
  localparam src_t SRC_CB   = 5'd27;
  localparam src_t SRC_CC   = 5'd28;
  localparam src_t SRC_ONE  = 5'd29;
  localparam src_t SRC_ZERO = 5'd30;

  localparam logic [1:0] OP_NOP   = 2'd0;
  localparam logic [1:0] OP_SINIT = 2'd1;
  localparam logic [1:0] OP_MUL   = 2'd2;
  localparam logic [1:0] OP_ACC   = 2'd3;

  localparam logic [2:0] PM_Q30  = 3'd0;
  localparam logic [2:0] PM_Q30N = 3'd1;
  localparam logic [2:0] PM_HORN = 3'd2;
  localparam logic [2:0] PM_SINF = 3'd3;
  localparam logic [2:0] PM_W16  = 3'd4;
  localparam logic [2:0] PM_DOT0 = 3'd5;
  localparam logic [2:0] PM_DOT  = 3'd6;

  localparam int PC_W = 7;
  localparam logic [PC_W-1:0] PC_LAST  = 7'd127;
  localparam logic [PC_W-1:0] PC_MODES = 7'd48;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] post;
    src_t       sa;
    src_t       sb;
    src_t       dst;
    logic [3:0] arg;
  } uop_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
    uop_t uop;
  } cmd_t;

  // Taylor coefficients of sin(pi/2 x) in Q6.30.
  function automatic val_t sin_coef(input logic [2:0] k);
    val_t c;
    unique case (k)
      3'd0:    c = 36'sd1686629713;
      3'd1:    c = -36'sd693598660;
      3'd2:    c = 36'sd85569306;
      3'd3:    c = -36'sd5026995;
      3'd4:    c = 36'sd172272;
      default: c = -36'sd3864;
    endcase
    return c;
  endfunction

  function automatic uop_t mk(input logic [1:0] op, input logic [2:0] post,
                              input src_t sa, input src_t sb, input src_t dst,
                              input logic [3:0] arg);
    uop_t u;
    u.op = op; u.post = post; u.sa = sa; u.sb = sb; u.dst = dst; u.arg = arg;
    return u;
  endfunction

  // Six sines of eight steps each, then five modes of sixteen steps each.
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    logic [PC_W-1:0] q;
    logic [2:0] m;
    logic [3:0] j;
    src_t sdst;
    q = pc - PC_MODES;
    m = q[6:4];
    j = q[3:0];
    unique case (pc[5:3])
      3'd0:    sdst = SRC_ST;
      3'd1:    sdst = SRC_CT;
      3'd2:    sdst = SRC_SP;
      3'd3:    sdst = SRC_CP;
      3'd4:    sdst = SRC_S2;
      default: sdst = SRC_C2;
    endcase
    u = mk(OP_NOP, PM_Q30, SRC_ZERO, SRC_ZERO, SRC_ZERO, 4'd0);
    if (pc < PC_MODES) begin
      unique case (pc[2:0])
        3'd0: u = mk(OP_SINIT, PM_Q30, SRC_ZERO, SRC_ZERO, SRC_X, {1'b0, pc[5:3]});
        3'd1: u = mk(OP_MUL, PM_Q30, SRC_X, SRC_X, SRC_Z, 4'd0);
        3'd2: u = mk(OP_MUL, PM_HORN, SRC_C5, SRC_Z, SRC_P, 4'd4);
        3'd7: u = mk(OP_MUL, PM_SINF, SRC_P, SRC_X, sdst, 4'd0);
        default: u = mk(OP_MUL, PM_HORN, SRC_P, SRC_Z, SRC_P, {1'b0, 3'd6 - pc[2:0]});
      endcase
    end else begin
      unique case (j)
        4'd0: begin
          unique case (m)
            3'd0:    u = mk(OP_MUL, PM_Q30, SRC_OMC, SRC_OMC, SRC_T, 4'd0);
            3'd1:    u = mk(OP_MUL, PM_Q30, SRC_ST, SRC_OMC, SRC_T, 4'd0);
            3'd2:    u = mk(OP_MUL, PM_Q30, SRC_ST, SRC_ST, SRC_T, 4'd0);
            3'd3:    u = mk(OP_MUL, PM_Q30, SRC_ST, SRC_OPC, SRC_T, 4'd0);
            default: u = mk(OP_MUL, PM_Q30, SRC_OPC, SRC_OPC, SRC_T, 4'd0);
          endcase
        end
        4'd1: begin
          unique case (m)
            3'd1, 3'd3: u = mk(OP_MUL, PM_Q30N, SRC_CB, SRC_T, SRC_K, 4'd0);
            3'd2:       u = mk(OP_MUL, PM_Q30, SRC_CC, SRC_T, SRC_K, 4'd0);
            default:    u = mk(OP_MUL, PM_Q30, SRC_CA, SRC_T, SRC_K, 4'd0);
          endcase
        end
        4'd2: begin
          unique case (m)
            3'd1, 3'd3: u = mk(OP_MUL, PM_Q30, SRC_K, SRC_CP, SRC_YR, 4'd0);
            3'd2:       u = mk(OP_MUL, PM_Q30, SRC_K, SRC_ONE, SRC_YR, 4'd0);
            default:    u = mk(OP_MUL, PM_Q30, SRC_K, SRC_C2, SRC_YR, 4'd0);
          endcase
        end
        4'd3: begin
          unique case (m)
            3'd0:    u = mk(OP_MUL, PM_Q30N, SRC_K, SRC_S2, SRC_YI, 4'd0);
            3'd1:    u = mk(OP_MUL, PM_Q30N, SRC_K, SRC_SP, SRC_YI, 4'd0);
            3'd2:    u = mk(OP_MUL, PM_Q30, SRC_K, SRC_ZERO, SRC_YI, 4'd0);
            3'd3:    u = mk(OP_MUL, PM_Q30, SRC_K, SRC_SP, SRC_YI, 4'd0);
            default: u = mk(OP_MUL, PM_Q30, SRC_K, SRC_S2, SRC_YI, 4'd0);
          endcase
        end
        4'd4:  u = mk(OP_MUL, PM_W16, SRC_W, SRC_HR, SRC_WR, 4'd0);
        4'd5:  u = mk(OP_MUL, PM_W16, SRC_W, SRC_HI, SRC_WI, 4'd0);
        4'd6:  u = mk(OP_MUL, PM_DOT0, SRC_WR, SRC_SRL, SRC_ZERO, 4'd0);
        4'd7:  u = mk(OP_MUL, PM_DOT, SRC_WR, SRC_SRH, SRC_ZERO, 4'd1);
        4'd8:  u = mk(OP_MUL, PM_DOT, SRC_WI, SRC_SIL, SRC_ZERO, 4'd0);
        4'd9:  u = mk(OP_MUL, PM_DOT, SRC_WI, SRC_SIH, SRC_ZERO, 4'd1);
        4'd10: u = mk(OP_ACC, PM_Q30, SRC_ZERO, SRC_ZERO, SRC_ZERO, {m, 1'b0});
        4'd11: u = mk(OP_MUL, PM_DOT0, SRC_WR, SRC_SIL, SRC_ZERO, 4'd0);
        4'd12: u = mk(OP_MUL, PM_DOT, SRC_WR, SRC_SIH, SRC_ZERO, 4'd1);
        4'd13: u = mk(OP_MUL, PM_DOT, SRC_NWI, SRC_SRL, SRC_ZERO, 4'd0);
        4'd14: u = mk(OP_MUL, PM_DOT, SRC_NWI, SRC_SRH, SRC_ZERO, 4'd1);
        default: u = mk(OP_ACC, PM_Q30, SRC_ZERO, SRC_ZERO, SRC_ZERO, {m, 1'b1});
      endcase
    end
    return u;
  endfunction

endpackage

@@ hdl/swl2mp_ctrl.sv @@
// Controller: handshakes and the microcode sequencer of the mode projection block.
module swl2mp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                last_point,
  output logic                out_valid,
  input  logic                out_stall,
  output swl2mp_pkg::cmd_t    cmd
);
  import swl2mp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]      state, state_next;
  logic [PC_W-1:0] pc;
  logic            last;
  logic            accept;
  logic            hold;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // The result register is busy while an unread word waits in it.
  assign hold     = out_valid && out_stall;

  always_comb begin
    cmd.load = accept;
    cmd.exec = (state == S_RUN);
    cmd.emit = (state == S_DONE) && last && !hold;
    cmd.uop  = ucode(pc);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_RUN;
      S_RUN:   if (pc == PC_LAST) state_next = S_DONE;
      S_DONE:  if (!last || !hold) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      last      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        pc   <= '0;
        last <= last_point;
      end else if (state == S_RUN) begin
        pc <= pc + 1'b1;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

endmodule

@@ hdl/swl2mp_dpath.sv @@
// Datapath: operand registers, shared multiplier, trig evaluation and the ten accumulators.
module swl2mp_dpath #(
  parameter int ANGLE_BITS  = 16,
  parameter int SAMPLE_BITS = 32,
  parameter int ACC_BITS    = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swl2mp_pkg::cmd_t              cmd,
  input  logic [ANGLE_BITS-1:0]         theta_angle,
  input  logic [ANGLE_BITS-1:0]         phi_angle,
  input  logic signed [SAMPLE_BITS-1:0] sample_re,
  input  logic signed [SAMPLE_BITS-1:0] sample_im,
  input  logic [31:0]                   point_weight,
  output logic [9:0][63:0]              sums
);
  import swl2mp_pkg::*;

  localparam int PROD_W = 2 * VAL_W;
  localparam int DACC_W = PROD_W + 26;
  localparam int SUM_W  = 67;
  localparam logic signed [PROD_W-1:0] RND30 = PROD_W'(64'sd536870912);
  localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(64'sd32768);
  localparam logic signed [DACC_W-1:0] RND32 = DACC_W'(64'sd2147483648);
  localparam logic signed [SUM_W-1:0] ACC_MAX =
    signed'({{(SUM_W-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);

  logic [31:0] ut, up;
  logic signed [47:0] sr, si;
  logic [31:0] w;
  logic [1:0] quad;
  val_t x, z, p, t, k, st, ct, sp, cp, s2, c2, yr, yi, wr, wi;
  logic signed [DACC_W-1:0] dacc;
  logic signed [ACC_BITS-1:0] acc [10];
  logic signed [ACC_BITS-1:0] outr [10];

  val_t a, b, res, q30, clamp;
  logic signed [PROD_W-1:0] prod;
  logic signed [DACC_W-1:0] dterm, dround;
  logic signed [SUM_W-1:0] tinc, asum, asat;
  logic [31:0] u, ubase;
  logic [1:0] uquad;
  val_t ux;

  function automatic val_t to_q16(input val_t v);
    val_t r;
    r = (v + 36'sd8192) >>> 14;
    return r;
  endfunction

  function automatic val_t pick(input src_t s, input val_t vx, input val_t vz,
                                input val_t vp, input val_t vt, input val_t vk,
                                input val_t vst, input val_t vct, input val_t vsp,
                                input val_t vcp, input val_t vs2, input val_t vc2,
                                input val_t vyr, input val_t vyi, input val_t vwr,
                                input val_t vwi, input logic [31:0] vw,
                                input logic signed [47:0] vsr,
                                input logic signed [47:0] vsi);
    val_t r;
    unique case (s)
      SRC_X:    r = vx;
      SRC_Z:    r = vz;
      SRC_P:    r = vp;
      SRC_T:    r = vt;
      SRC_K:    r = vk;
      SRC_ST:   r = vst;
      SRC_CT:   r = vct;
      SRC_SP:   r = vsp;
      SRC_CP:   r = vcp;
      SRC_S2:   r = vs2;
      SRC_C2:   r = vc2;
      SRC_YR:   r = vyr;
      SRC_YI:   r = vyi;
      SRC_WR:   r = vwr;
      SRC_WI:   r = vwi;
      SRC_NWI:  r = -vwi;
      SRC_OMC:  r = Q30_ONE - vct;
      SRC_OPC:  r = Q30_ONE + vct;
      SRC_HR:   r = to_q16(vyr);
      SRC_HI:   r = to_q16(vyi);
      SRC_W:    r = signed'({4'b0, vw});
      SRC_SRL:  r = signed'({12'b0, vsr[23:0]});
      SRC_SRH:  r = VAL_W'(signed'(vsr[47:24]));
      SRC_SIL:  r = signed'({12'b0, vsi[23:0]});
      SRC_SIH:  r = VAL_W'(signed'(vsi[47:24]));
      SRC_C5:   r = sin_coef(3'd5);
      SRC_CA:   r = COEF_A;
      SRC_CB:   r = COEF_B;
      SRC_CC:   r = COEF_C;
      SRC_ONE:  r = Q30_ONE;
      default:  r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    a = pick(cmd.uop.sa, x, z, p, t, k, st, ct, sp, cp, s2, c2, yr, yi, wr, wi, w, sr, si);
    b = pick(cmd.uop.sb, x, z, p, t, k, st, ct, sp, cp, s2, c2, yr, yi, wr, wi, w, sr, si);
    prod = a * b;
    q30 = VAL_W'((prod + RND30) >>> 30);
    if (q30 < 0) clamp = '0;
    else if (q30 > Q30_ONE) clamp = Q30_ONE;
    else clamp = q30;
    unique case (cmd.uop.post)
      PM_Q30N: res = -q30;
      PM_HORN: res = sin_coef(cmd.uop.arg[2:0]) + q30;
      PM_SINF: res = quad[1] ? -clamp : clamp;
      PM_W16:  res = VAL_W'((prod + RND16) >>> 16);
      default: res = q30;
    endcase
    dterm = cmd.uop.arg[0] ? (DACC_W'(prod) <<< 24) : DACC_W'(prod);
    dround = (dacc + RND32) >>> 32;
    tinc = SUM_W'(dround);
    asum = SUM_W'(acc[cmd.uop.arg]) + tinc;
    if (asum > ACC_MAX) asat = ACC_MAX;
    else if (asum < ACC_MIN) asat = ACC_MIN;
    else asat = asum;
    // Angle select: theta, phi or twice phi, cosine is a quarter turn on.
    unique case (cmd.uop.arg[2:1])
      2'd0:    ubase = ut;
      2'd1:    ubase = up;
      default: ubase = up << 1;
    endcase
    u = ubase + (cmd.uop.arg[0] ? 32'h4000_0000 : 32'h0);
    uquad = u[31:30];
    ux = uquad[0] ? Q30_ONE - signed'({6'b0, u[29:0]}) : signed'({6'b0, u[29:0]});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ut <= 32'(theta_angle) << (32 - ANGLE_BITS);
      up <= 32'(phi_angle) << (32 - ANGLE_BITS);
      sr <= 48'(sample_re);
      si <= 48'(sample_im);
      w  <= point_weight;
    end
    if (cmd.exec) begin
      unique case (cmd.uop.op)
        OP_SINIT: begin
          x    <= ux;
          quad <= uquad;
        end
        OP_MUL: begin
          if (cmd.uop.post == PM_DOT0) dacc <= dterm;
          else if (cmd.uop.post == PM_DOT) dacc <= dacc + dterm;
          else begin
            unique case (cmd.uop.dst)
              SRC_Z:   z  <= res;
              SRC_P:   p  <= res;
              SRC_T:   t  <= res;
              SRC_K:   k  <= res;
              SRC_ST:  st <= res;
              SRC_CT:  ct <= res;
              SRC_SP:  sp <= res;
              SRC_CP:  cp <= res;
              SRC_S2:  s2 <= res;
              SRC_C2:  c2 <= res;
              SRC_YR:  yr <= res;
              SRC_YI:  yi <= res;
              SRC_WR:  wr <= res;
              SRC_WI:  wi <= res;
              default: x  <= res;
            endcase
          end
        end
        default: ;
      endcase
    end
    if (cmd.emit) begin
      for (int i = 0; i < 10; i++) outr[i] <= acc[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 10; i++) acc[i] <= '0;
    end else if (cmd.emit) begin
      for (int i = 0; i < 10; i++) acc[i] <= '0;
    end else if (cmd.exec && cmd.uop.op == OP_ACC) begin
      acc[cmd.uop.arg] <= ACC_BITS'(asat);
    end
  end

  always_comb begin
    for (int i = 0; i < 10; i++) sums[i] = 64'(outr[i]);
  end

endmodule

@@ hdl/spin_weighted_l2_mode_projection_core.sv @@
// Top level of the spin-weight -2, l = 2 mode projection block.
// Each word is accepted, then runs 128 microcode steps on the single
// shared 36 x 36 multiplier (six sines, five harmonics, weighting, exact dots),
// and ends in a finish step; the next word is accepted in the cycle after that.
// A last point finishes when no result waits unread; its sums follow next cycle.
// Synchronous reset clears the accumulators, the sequencer and the result valid.
module spin_weighted_l2_mode_projection_core #(
  parameter int ANGLE_BITS  = 16,
  parameter int SAMPLE_BITS = 32,
  parameter int ACC_BITS    = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ANGLE_BITS-1:0]         theta_angle,
  input  logic [ANGLE_BITS-1:0]         phi_angle,
  input  logic signed [SAMPLE_BITS-1:0] sample_re,
  input  logic signed [SAMPLE_BITS-1:0] sample_im,
  input  logic [31:0]                   point_weight,
  input  logic                          last_point,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [63:0]            sum_m_minus2_re,
  output logic signed [63:0]            sum_m_minus2_im,
  output logic signed [63:0]            sum_m_minus1_re,
  output logic signed [63:0]            sum_m_minus1_im,
  output logic signed [63:0]            sum_m_zero_re,
  output logic signed [63:0]            sum_m_zero_im,
  output logic signed [63:0]            sum_m_plus1_re,
  output logic signed [63:0]            sum_m_plus1_im,
  output logic signed [63:0]            sum_m_plus2_re,
  output logic signed [63:0]            sum_m_plus2_im
);
  import swl2mp_pkg::*;
  `include "assert_macros.svh"

  cmd_t cmd;
  logic [9:0][63:0] sums;

  swl2mp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .last_point (last_point),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd)
  );

  swl2mp_dpath #(
    .ANGLE_BITS  (ANGLE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .theta_angle  (theta_angle),
    .phi_angle    (phi_angle),
    .sample_re    (sample_re),
    .sample_im    (sample_im),
    .point_weight (point_weight),
    .sums         (sums)
  );

  assign sum_m_minus2_re = sums[0];
  assign sum_m_minus2_im = sums[1];
  assign sum_m_minus1_re = sums[2];
  assign sum_m_minus1_im = sums[3];
  assign sum_m_zero_re   = sums[4];
  assign sum_m_zero_im   = sums[5];
  assign sum_m_plus1_re  = sums[6];
  assign sum_m_plus1_im  = sums[7];
  assign sum_m_plus2_re  = sums[8];
  assign sum_m_plus2_im  = sums[9];

  `SWL_ASSERT(a_exec_busy, clk, rst, cmd.exec |-> in_stall, "microcode runs while accepting")
  `SWL_ASSERT(a_emit_free, clk, rst, cmd.emit |-> !(out_valid && out_stall), "pending word overwritten")
  `SWL_ASSERT(a_emit_valid, clk, rst, cmd.emit |=> out_valid, "emitted word not presented")
  `SWL_ASSERT(a_load_accept, clk, rst, cmd.load |-> (in_valid && !cmd.exec && !cmd.emit), "load outside accept")

endmodule
